FILE: rtl/sql_token_lexer_core_assert.svh
// Assertion macros shared by the lexer checker
`ifndef SQL_TOKEN_LEXER_CORE_ASSERT_SVH
`define SQL_TOKEN_LEXER_CORE_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define SLX_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define SLX_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: rtl/slx_pkg.sv
// Shared types and constants for the SQL token lexer
`timescale 1ns / 1ps
package slx_pkg;
  localparam int unsigned MaxTokenLen = 32;

  localparam logic [5:0] K_END    = 6'd0;
  localparam logic [5:0] K_ERROR  = 6'd1;
  localparam logic [5:0] K_IDENT  = 6'd2;
  localparam logic [5:0] K_NUMBER = 6'd3;
  localparam logic [5:0] K_STRING = 6'd4;
  localparam logic [5:0] K_SEMI   = 6'd5;
  localparam logic [5:0] K_EQ     = 6'd6;
  localparam logic [5:0] K_LT     = 6'd7;
  localparam logic [5:0] K_LE     = 6'd8;
  localparam logic [5:0] K_GT     = 6'd9;
  localparam logic [5:0] K_GE     = 6'd10;
  localparam logic [5:0] K_COMMA  = 6'd11;
  localparam logic [5:0] K_DOT    = 6'd12;
  localparam logic [5:0] K_COLON  = 6'd13;
  localparam logic [5:0] K_LBRACE = 6'd14;
  localparam logic [5:0] K_RBRACE = 6'd15;
  localparam logic [5:0] K_LPAREN = 6'd16;
  localparam logic [5:0] K_RPAREN = 6'd17;
  localparam logic [5:0] K_KW0    = 6'd18;

  // command from front to back
  typedef enum logic [1:0] {
    CMD_SINGLE = 2'd0,  // one result without text
    CMD_TEXT   = 2'd1   // replay buffered text, kind given
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [5:0] kind;
    logic [5:0] len;    // text length for CMD_TEXT
    logic       last;   // final command of this byte
  } cmd_t;

  // keyword text, packed 8 chars, first char in low byte
  function automatic logic [63:0] kw_word(input logic [3:0] k);
    logic [63:0] w;
    case (k)
      4'd0:  w = {16'h0, "etaerc"};
      4'd1:  w = {24'h0, "elbat"};
      4'd2:  w = {40'h0, "tni"};
      4'd3:  w = {32'h0, "rahc"};
      4'd4:  w = {32'h0, "morf"};
      4'd5:  w = {16'h0, "tresni"};
      4'd6:  w = {32'h0, "otni"};
      4'd7:  w = {16'h0, "seulav"};
      4'd8:  w = {16'h0, "tceles"};
      4'd9:  w = {24'h0, "erehw"};
      4'd10: w = {24'h0, "renni"};
      4'd11: w = {32'h0, "nioj"};
      4'd12: w = {48'h0, "no"};
      4'd13: w = {16'h0, "eteled"};
      4'd14: w = {8'h0, "yramirp"};
      default: w = {40'h0, "yek"};
    endcase
    return w;
  endfunction

  function automatic logic [3:0] kw_len(input logic [3:0] k);
    logic [3:0] l;
    case (k)
      4'd0, 4'd5, 4'd7, 4'd8, 4'd13: l = 4'd6;
      4'd1, 4'd9, 4'd10:             l = 4'd5;
      4'd2, 4'd15:                   l = 4'd3;
      4'd12:                         l = 4'd2;
      4'd14:                         l = 4'd7;
      default:                       l = 4'd4;
    endcase
    return l;
  endfunction
endpackage

FILE: rtl/sql_token_lexer_core.sv
// Top level of the streaming SQL token lexer
// The front closes or extends a pending token and, unless that uses the byte up, treats
// it as in idle; requests pass a two-entry queue to the back end and its output register,
// and results wait while pop is held off. The front takes no new byte until the last is
// done; replay reads one character at a time; a new text token waits for the last replay.
// Reset (rst_ni low, asynchronous): idle mode, empty queues, no result shown.
`timescale 1ns / 1ps
module sql_token_lexer_core import slx_pkg::*; #(
  parameter int unsigned MaxLen = MaxTokenLen
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic [5:0] token_kind_o,
  output logic [7:0] text_char_o,
  output logic       has_text_o,
  output logic       token_end_o,
  output logic       run_last_o
);
  localparam int unsigned AW = $clog2(MaxLen);

  logic          cq_push, cq_full, buf_busy, wr_en;
  cmd_t          cq_cmd;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [7:0]    wr_data, rd_data;

  // front: classify bytes, buffer text, issue requests
  slx_front #(.MaxLen(MaxLen)) u_front (
    .clk_i, .rst_ni, .push_i(push), .in_byte_i, .full_o(full),
    .cq_push_o(cq_push), .cq_cmd_o(cq_cmd), .cq_full_i(cq_full),
    .wr_en_o(wr_en), .wr_addr_o(wr_addr), .wr_data_o(wr_data),
    .buf_busy_i(buf_busy)
  );

  // token text store
  slx_ram #(.Width(8), .Depth(MaxLen)) u_text (
    .clk_i, .we_i(wr_en), .waddr_i(wr_addr), .wdata_i(wr_data),
    .raddr_i(rd_addr), .rdata_o(rd_data)
  );

  // back: request queue, replay, output register
  slx_back #(.MaxLen(MaxLen)) u_back (
    .clk_i, .rst_ni, .cq_push_i(cq_push), .cq_cmd_i(cq_cmd), .cq_full_o(cq_full),
    .buf_busy_o(buf_busy), .rd_addr_o(rd_addr), .rd_data_i(rd_data),
    .pop_i(pop), .empty_o(empty), .token_kind_o, .text_char_o, .has_text_o,
    .token_end_o, .run_last_o
  );
endmodule

FILE: rtl/slx_ram.sv
// Generic single-port-write, registered-read RAM
`timescale 1ns / 1ps
module slx_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: rtl/slx_front.sv
// Front end: byte classification, mode tracking, text buffering, keyword match
`timescale 1ns / 1ps
module slx_front import slx_pkg::*; #(
  parameter int unsigned MaxLen = MaxTokenLen
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic [7:0] in_byte_i,
  output logic       full_o,
  // command queue write side
  output logic       cq_push_o,
  output cmd_t       cq_cmd_o,
  input  logic       cq_full_i,
  // text buffer write side
  output logic                      wr_en_o,
  output logic [$clog2(MaxLen)-1:0] wr_addr_o,
  output logic [7:0]                wr_data_o,
  // buffer busy while back has queued or active requests
  input  logic       buf_busy_i
);
  localparam logic [2:0] M_IDLE = 3'd0, M_IDENT = 3'd1, M_NUMBER = 3'd2,
                         M_STRING = 3'd3, M_LESS = 3'd4, M_GREATER = 3'd5;
  localparam int unsigned AW = $clog2(MaxLen);
  localparam logic [5:0] MaxLen6 = 6'(MaxLen);

  logic [2:0]  mode_q, mode_d;
  logic [5:0]  len_q, len_d;
  logic        ovf_q, ovf_d;
  logic [63:0] kwbuf_q, kwbuf_d;   // first eight chars for keyword matching
  // a byte may cause up to two commands; stage them over cycles
  logic        busy_q, busy_d;
  logic [7:0]  byte_q, byte_d;
  logic [1:0]  ph_q, ph_d;         // phase within one byte
  logic        fire;

  // idle classification
  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction
  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction
  // bytes that give no result when seen in idle
  function automatic logic idle_quiet(input logic [7:0] c);
    return c == " " || c == 8'h09 || c == 8'h0d || c == 8'h0a || c == "<" || c == ">" ||
           c == "'" || is_digit(c) || is_alpha(c) || c == "_";
  endfunction

  logic [7:0] c, lc;
  logic       ident_kw;
  logic [5:0] kw_kind;
  cmd_t       cmd;
  logic       emit, done;

  assign full_o = busy_q;

  always_comb begin
    ident_kw = 1'b0;
    kw_kind  = K_IDENT;
    for (int k = 15; k >= 0; k--) begin
      if ({2'b0, kw_len(4'(k))} == len_q && !ovf_q &&
          kw_word(4'(k)) == kwbuf_q) begin
        ident_kw = 1'b1;
        kw_kind  = K_KW0 + 6'(k);
      end
    end
  end

  always_comb begin
    c = byte_q;
    lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    mode_d = mode_q; len_d = len_q; ovf_d = ovf_q; kwbuf_d = kwbuf_q;
    busy_d = busy_q; byte_d = byte_q; ph_d = ph_q;
    emit = 1'b0; done = 1'b0;
    cmd = '{cmd: CMD_SINGLE, kind: K_ERROR, len: len_q, last: 1'b0};
    wr_en_o = 1'b0;
    wr_addr_o = len_q[AW-1:0];
    wr_data_o = lc;

    if (!busy_q) begin
      if (push_i) begin
        busy_d = 1'b1; byte_d = in_byte_i; ph_d = 2'd0;
      end
    end else if (ph_q == 2'd0) begin
      // close or extend a pending token
      case (mode_q)
        M_IDENT, M_NUMBER: begin
          if ((mode_q == M_IDENT && (is_digit(c) || is_alpha(c) || c == "_")) ||
              (mode_q == M_NUMBER && is_digit(c))) begin
            if (len_q < MaxLen6) begin
              if (!buf_busy_i) begin
                wr_en_o = 1'b1;
                if (len_q < 6'd8) kwbuf_d[len_q[2:0]*8 +: 8] = lc;
                len_d = len_q + 6'd1;
                done = 1'b1;
              end
            end else begin
              ovf_d = 1'b1; done = 1'b1;
            end
          end else begin
            emit = 1'b1;
            // last request of the byte when the closing byte itself gives nothing
            cmd.last = idle_quiet(c);
            if (ovf_q) cmd.kind = K_ERROR;
            else if (mode_q == M_IDENT && ident_kw) cmd.kind = kw_kind;
            else begin
              cmd.cmd  = CMD_TEXT;
              cmd.kind = (mode_q == M_IDENT) ? K_IDENT : K_NUMBER;
            end
            if (!cq_full_i) begin mode_d = M_IDLE; ph_d = 2'd1; end
          end
        end
        M_STRING: begin
          if (c == "'") begin
            emit = 1'b1; cmd.last = 1'b1;
            if (ovf_q) cmd.kind = K_ERROR;
            else begin cmd.cmd = CMD_TEXT; cmd.kind = K_STRING; end
            if (!cq_full_i) begin mode_d = M_IDLE; done = 1'b1; end
          end else if (c == 8'd0) begin
            emit = 1'b1; cmd.kind = K_ERROR;
            if (!cq_full_i) begin mode_d = M_IDLE; ph_d = 2'd1; end
          end else if (len_q < MaxLen6) begin
            if (!buf_busy_i) begin
              wr_en_o = 1'b1; wr_data_o = c;
              len_d = len_q + 6'd1; done = 1'b1;
            end
          end else begin
            ovf_d = 1'b1; done = 1'b1;
          end
        end
        M_LESS, M_GREATER: begin
          emit = 1'b1;
          if (c == "=") begin
            cmd.kind = (mode_q == M_LESS) ? K_LE : K_GE; cmd.last = 1'b1;
            if (!cq_full_i) begin mode_d = M_IDLE; done = 1'b1; end
          end else begin
            cmd.kind = (mode_q == M_LESS) ? K_LT : K_GT;
            cmd.last = idle_quiet(c);
            if (!cq_full_i) begin mode_d = M_IDLE; ph_d = 2'd1; end
          end
        end
        default: ph_d = 2'd1;
      endcase
    end else begin
      // byte as seen in idle
      cmd.last = 1'b1;
      case (c)
        " ", 8'h09, 8'h0d, 8'h0a: done = 1'b1;
        8'h00: begin emit = 1'b1; cmd.kind = K_END; end
        ";":   begin emit = 1'b1; cmd.kind = K_SEMI; end
        "=":   begin emit = 1'b1; cmd.kind = K_EQ; end
        ",":   begin emit = 1'b1; cmd.kind = K_COMMA; end
        ".":   begin emit = 1'b1; cmd.kind = K_DOT; end
        ":":   begin emit = 1'b1; cmd.kind = K_COLON; end
        "{":   begin emit = 1'b1; cmd.kind = K_LBRACE; end
        "}":   begin emit = 1'b1; cmd.kind = K_RBRACE; end
        "(":   begin emit = 1'b1; cmd.kind = K_LPAREN; end
        ")":   begin emit = 1'b1; cmd.kind = K_RPAREN; end
        "<":   begin mode_d = M_LESS; done = 1'b1; end
        ">":   begin mode_d = M_GREATER; done = 1'b1; end
        "'":   begin
          mode_d = M_STRING; len_d = '0; ovf_d = 1'b0; kwbuf_d = '0; done = 1'b1;
        end
        default: begin
          if (is_digit(c) || is_alpha(c) || c == "_") begin
            // new token overwrites buffer; wait until replay has read it
            if (!buf_busy_i) begin
              wr_en_o = 1'b1; wr_addr_o = '0;
              mode_d = is_digit(c) ? M_NUMBER : M_IDENT;
              len_d = 6'd1; ovf_d = 1'b0;
              kwbuf_d = {56'h0, lc};
              done = 1'b1;
            end
          end else begin
            emit = 1'b1; cmd.kind = K_ERROR;
          end
        end
      endcase
      if (emit && !cq_full_i) done = 1'b1;
      if (emit && cq_full_i) done = 1'b0;
    end
    if (done) busy_d = 1'b0;
  end

  assign fire = emit && !cq_full_i;
  assign cq_push_o = fire;
  assign cq_cmd_o  = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE; len_q <= '0; ovf_q <= 1'b0; busy_q <= 1'b0; ph_q <= '0;
    end else begin
      mode_q <= mode_d; len_q <= len_d; ovf_q <= ovf_d; busy_q <= busy_d;
      ph_q <= ph_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kwbuf_q <= kwbuf_d;
    byte_q  <= byte_d;
  end
endmodule

FILE: rtl/slx_back.sv
// Back end: command queue and result generation with text replay
`timescale 1ns / 1ps
module slx_back import slx_pkg::*; #(
  parameter int unsigned MaxLen = MaxTokenLen
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cq_push_i,
  input  cmd_t       cq_cmd_i,
  output logic       cq_full_o,
  output logic       buf_busy_o,
  output logic [$clog2(MaxLen)-1:0] rd_addr_o,
  input  logic [7:0] rd_data_i,
  input  logic       pop_i,
  output logic       empty_o,
  output logic [5:0] token_kind_o,
  output logic [7:0] text_char_o,
  output logic       has_text_o,
  output logic       token_end_o,
  output logic       run_last_o
);
  localparam int unsigned AW = $clog2(MaxLen);

  // two-entry command queue
  cmd_t       q_mem [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  // replay engine
  logic       act_q;       // command in progress
  cmd_t       cur_q;
  logic [5:0] idx_q;       // next address to read
  logic       rv_q;        // read data valid this cycle
  logic [5:0] rix_q;       // index of data in flight
  // output register
  logic       ov_q;
  logic [5:0] ok_q;
  logic [7:0] oc_q;
  logic       oh_q, oe_q, ol_q;

  logic take_cmd, cq_pop, out_free, issue, fin, ov_set;

  assign cq_full_o  = cnt_q[1];
  assign out_free   = !ov_q || pop_i;
  // text is owned by the back end from enqueue until its last read
  assign buf_busy_o = (cnt_q != 2'd0) || act_q;
  assign take_cmd   = !act_q && cnt_q != 2'd0;
  assign cq_pop     = take_cmd;
  // read issue: only when the output can absorb the data next cycle
  assign issue = act_q && cur_q.cmd == CMD_TEXT && cur_q.len != 6'd0 &&
                 idx_q < cur_q.len && !rv_q && out_free;
  assign rd_addr_o = idx_q[AW-1:0];
  assign fin = rv_q && (rix_q + 6'd1 == cur_q.len);
  // output register loaded this cycle
  assign ov_set = rv_q || (act_q && !take_cmd && out_free &&
                           (cur_q.cmd != CMD_TEXT || cur_q.len == 6'd0));

  assign empty_o      = !ov_q;
  assign token_kind_o = ok_q;
  assign text_char_o  = oc_q;
  assign has_text_o   = oh_q;
  assign token_end_o  = oe_q;
  assign run_last_o   = ol_q;

  always_ff @(posedge clk_i) begin
    if (cq_push_i) q_mem[wp_q] <= cq_cmd_i;
    if (take_cmd) cur_q <= q_mem[rp_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0; act_q <= 1'b0;
      idx_q <= '0; rv_q <= 1'b0; rix_q <= '0; ov_q <= 1'b0;
    end else begin
      if (cq_push_i) wp_q <= !wp_q;
      if (cq_pop) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, cq_push_i} - {1'b0, cq_pop};
      if (ov_set) ov_q <= 1'b1;
      else if (ov_q && pop_i) ov_q <= 1'b0;
      if (take_cmd) begin
        act_q <= 1'b1; idx_q <= '0;
      end else if (act_q) begin
        if (cur_q.cmd != CMD_TEXT || cur_q.len == 6'd0) begin
          if (out_free) act_q <= 1'b0;
        end else begin
          if (issue) begin idx_q <= idx_q + 6'd1; rix_q <= idx_q; end
          rv_q <= issue;
          if (fin) act_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (act_q && !take_cmd) begin
      if (cur_q.cmd != CMD_TEXT || cur_q.len == 6'd0) begin
        if (out_free) begin
          ok_q <= cur_q.kind; oc_q <= '0; oh_q <= 1'b0; oe_q <= 1'b1;
          ol_q <= cur_q.last;
        end
      end else if (rv_q) begin
        ok_q <= cur_q.kind; oc_q <= rd_data_i; oh_q <= 1'b1;
        oe_q <= fin; ol_q <= fin && cur_q.last;
      end
    end
  end
endmodule

FILE: rtl/slx_checker.sv
// Port-level checker for the lexer, bound to the top level
`timescale 1ns / 1ps
`include "sql_token_lexer_core_assert.svh"
module slx_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [5:0] token_kind_o,
  input logic [7:0] text_char_o,
  input logic       has_text_o,
  input logic       token_end_o,
  input logic       run_last_o
);
  `SLX_ASSERT_IMP(a_kind_range, clk_i, rst_ni, !empty, token_kind_o <= 6'd33)
  `SLX_ASSERT_IMP(a_notext_zero, clk_i, rst_ni, !empty && !has_text_o, text_char_o == 8'd0)
  `SLX_ASSERT_IMP(a_last_ends, clk_i, rst_ni, !empty && run_last_o, token_end_o)
  `SLX_ASSERT_NEXT(a_hold, clk_i, rst_ni, !empty && !pop, !empty && $stable(token_kind_o))
endmodule

bind sql_token_lexer_core slx_checker u_chk (
  .clk_i, .rst_ni, .empty, .pop, .token_kind_o, .text_char_o, .has_text_o,
  .token_end_o, .run_last_o
);

FILE: tb/sv/sql_token_lexer_core_test.sv
// Testbench for the streaming SQL token lexer: byte stream in, token results checked
`timescale 1ns / 1ps
module sql_token_lexer_core_test;
  import slx_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainWait  = 40;

  // one expected token result
  typedef struct packed {
    logic [5:0] kind;
    logic [7:0] ch;
    logic       has;
    logic       tend;
    logic       rlast;
  } tok_t;

  typedef enum logic [2:0] {
    LM_IDLE, LM_IDENT, LM_NUMBER, LM_STRING, LM_LESS, LM_GREATER
  } lmode_e;

  logic       clk_i;
  logic       rst_ni;
  logic       push;
  logic       full;
  logic [7:0] in_byte_i;
  logic       empty;
  logic       pop;
  logic [5:0] token_kind_o;
  logic [7:0] text_char_o;
  logic       has_text_o;
  logic       token_end_o;
  logic       run_last_o;

  sql_token_lexer_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_byte_i   (in_byte_i),
    .empty       (empty),
    .pop         (pop),
    .token_kind_o(token_kind_o),
    .text_char_o (text_char_o),
    .has_text_o  (has_text_o),
    .token_end_o (token_end_o),
    .run_last_o  (run_last_o)
  );

  // predictor state
  lmode_e     lx_mode;
  logic [7:0] lx_text [MaxTokenLen];
  int         lx_len;
  logic       lx_ovf;

  logic [7:0] pending_bytes[$];
  tok_t       expected_tokens[$];
  tok_t       byte_toks[$];

  int  mismatches;
  int  cycles;
  bit  hold_rx;
  int  hold_left;
  bit  calm;   // no idling stretch

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic bit is_dig(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction
  function automatic bit is_alp(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction
  function automatic logic [7:0] lower(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  task automatic emit(logic [5:0] k, logic [7:0] c, logic h, logic e);
    tok_t t;
    t.kind = k; t.ch = h ? c : 8'd0; t.has = h; t.tend = e; t.rlast = 1'b0;
    byte_toks.push_back(t);
  endtask

  task automatic add_char(logic [7:0] c);
    if (lx_len < MaxTokenLen) begin
      lx_text[lx_len] = c;
      lx_len++;
    end else begin
      lx_ovf = 1'b1;
    end
  endtask

  task automatic begin_text(lmode_e m);
    lx_mode = m; lx_len = 0; lx_ovf = 1'b0;
  endtask

  task automatic replay_text(logic [5:0] k);
    if (lx_ovf) emit(K_ERROR, 0, 0, 1);
    else if (lx_len == 0) emit(k, 0, 0, 1);
    else for (int i = 0; i < lx_len; i++) emit(k, lx_text[i], 1, i + 1 == lx_len);
  endtask

  // keyword table as plain strings, index = kind - K_KW0
  task automatic close_ident();
    string kws[16];
    bit    hit;
    kws = '{"create", "table", "int", "char", "from", "insert", "into", "values",
            "select", "where", "inner", "join", "on", "delete", "primary", "key"};
    if (!lx_ovf) begin
      for (int k = 0; k < 16; k++) begin
        if (kws[k].len() == lx_len) begin
          hit = 1;
          for (int i = 0; i < lx_len; i++) if (kws[k][i] != lx_text[i]) hit = 0;
          if (hit) begin
            emit(K_KW0 + 6'(k), 0, 0, 1);
            return;
          end
        end
      end
    end
    replay_text(K_IDENT);
  endtask

  task automatic idle_char(logic [7:0] c);
    lx_mode = LM_IDLE;
    case (c)
      " ", "\t", 8'h0d, "\n": ;
      8'h00: emit(K_END, 0, 0, 1);
      ";": emit(K_SEMI, 0, 0, 1);
      "=": emit(K_EQ, 0, 0, 1);
      ",": emit(K_COMMA, 0, 0, 1);
      ".": emit(K_DOT, 0, 0, 1);
      ":": emit(K_COLON, 0, 0, 1);
      "{": emit(K_LBRACE, 0, 0, 1);
      "}": emit(K_RBRACE, 0, 0, 1);
      "(": emit(K_LPAREN, 0, 0, 1);
      ")": emit(K_RPAREN, 0, 0, 1);
      "<": lx_mode = LM_LESS;
      ">": lx_mode = LM_GREATER;
      "'": begin_text(LM_STRING);
      default: begin
        if (is_dig(c)) begin
          begin_text(LM_NUMBER); add_char(c);
        end else if (is_alp(c) || c == "_") begin
          begin_text(LM_IDENT); add_char(lower(c));
        end else begin
          emit(K_ERROR, 0, 0, 1);
        end
      end
    endcase
  endtask

  // works out the results of one accepted byte
  task automatic lex_byte(logic [7:0] c);
    bit lt;
    byte_toks.delete();
    case (lx_mode)
      LM_IDENT:
        if (is_dig(c) || is_alp(c) || c == "_") add_char(lower(c));
        else begin
          close_ident(); idle_char(c);
        end
      LM_NUMBER:
        if (is_dig(c)) add_char(c);
        else begin
          replay_text(K_NUMBER); idle_char(c);
        end
      LM_STRING:
        if (c == "'") begin
          replay_text(K_STRING); lx_mode = LM_IDLE;
        end else if (c == 8'h00) begin
          emit(K_ERROR, 0, 0, 1); idle_char(c);
        end else add_char(c);
      LM_LESS, LM_GREATER: begin
        lt = (lx_mode == LM_LESS);
        lx_mode = LM_IDLE;
        if (c == "=") emit(lt ? K_LE : K_GE, 0, 0, 1);
        else begin
          emit(lt ? K_LT : K_GT, 0, 0, 1); idle_char(c);
        end
      end
      default: idle_char(c);
    endcase
    if (byte_toks.size() > 0) byte_toks[byte_toks.size() - 1].rlast = 1'b1;
    foreach (byte_toks[i]) expected_tokens.push_back(byte_toks[i]);
  endtask

  task automatic queue_str(string s);
    for (int i = 0; i < s.len(); i++) pending_bytes.push_back(s[i]);
  endtask

  function automatic logic [7:0] rand_from(string s);
    return s[$urandom_range(s.len() - 1)];
  endfunction

  // random SQL-ish fragment, including random bytes, unclosed strings and overlong tokens
  task automatic queue_fragment();
    string kws[8];
    int n;
    kws = '{"SELECT", "from", "Where", "insert", "into", "values", "key", "on"};
    case ($urandom_range(9))
      0, 1: queue_str(kws[$urandom_range(7)]);
      2, 3: begin
        n = ($urandom_range(19) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 8);
        pending_bytes.push_back(rand_from("abcXYZ_q"));
        for (int i = 1; i < n; i++) pending_bytes.push_back(rand_from("azAZ09_m"));
      end
      4: begin
        n = ($urandom_range(19) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 6);
        for (int i = 0; i < n; i++) pending_bytes.push_back(rand_from("0123456789"));
      end
      5: begin
        n = ($urandom_range(19) == 0) ? $urandom_range(30, 40) : $urandom_range(0, 6);
        pending_bytes.push_back("'");
        for (int i = 0; i < n; i++) pending_bytes.push_back($urandom_range(1, 255) == 39 ?
                                                           8'd32 : 8'($urandom_range(1, 255)));
        if ($urandom_range(9) != 0) pending_bytes.push_back("'");
      end
      6: queue_str($urandom_range(1) ? "<=" : ">=");
      7: pending_bytes.push_back(rand_from(";=<>,.:{}()"));
      8: pending_bytes.push_back(8'($urandom_range(255)));
      default: pending_bytes.push_back($urandom_range(3) == 0 ? 8'h00 : 8'h20);
    endcase
    if ($urandom_range(2) == 0) pending_bytes.push_back(rand_from(" \t\n"));
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push      <= 1'b0;
      in_byte_i <= 8'h00;
    end else begin
      if (push && !full) begin
        lex_byte(in_byte_i);
        void'(pending_bytes.pop_front());
      end
      // keep request stable while it is waiting
      if (!(push && full)) begin
        if (pending_bytes.size() > 0 && (calm || $urandom_range(99) >= 38)) begin
          push      <= 1'b1;
          in_byte_i <= pending_bytes[0];
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver
  always @(posedge clk_i or negedge rst_ni) begin
    tok_t got, want;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        got = '{token_kind_o, text_char_o, has_text_o, token_end_o, run_last_o};
        if (expected_tokens.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result kind=%0d", got.kind);
        end else begin
          want = expected_tokens.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp kind=%0d ch=%h has=%b end=%b last=%b,",
                       want.kind, want.ch, want.has, want.tend, want.rlast,
                       " got kind=%0d ch=%h has=%b end=%b last=%b",
                       got.kind, got.ch, got.has, got.tend, got.rlast);
          end
        end
      end
      if (hold_left > 0) hold_left <= hold_left - 1;
      pop <= !(hold_rx || hold_left > 0) && (calm || $urandom_range(99) >= 38);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // the sent byte is advanced in the driver; reassign pending head before next push
  // (the driver reads pending_bytes[0] after popping the accepted one)

  initial begin
    lx_mode = LM_IDLE; lx_len = 0; lx_ovf = 1'b0;
    mismatches = 0; cycles = 0;
    hold_rx = 0; hold_left = 0; calm = 0;
    push = 1'b0; pop = 1'b0; in_byte_i = 8'h00;
    rst_ni = 1'b0;
    // directed part: keywords, case folding, punctuators, special cases
    queue_str("CREATE table x_1 ");
    queue_str("<=>= < 7>a ;=,.:{}()");
    queue_str("'' 'it' 123abc #");
    pending_bytes.push_back(8'hff);
    pending_bytes.push_back(8'h00);
    queue_str("'open");
    pending_bytes.push_back(8'h00);
    queue_str("abcdefghijklmnopqrstuvwxyz0123456789 select");
    pending_bytes.push_back(8'h0d);
    pending_bytes.push_back(8'h80);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    // long receiver hold-off while the sender keeps offering
    hold_left = 400;
    wait (pending_bytes.size() == 0);
    // random part, with one stretch without idling
    for (int i = 0; i < 70; i++) queue_fragment();
    wait (pending_bytes.size() < 50);
    calm = 1;
    wait (pending_bytes.size() == 0);
    calm = 0;
    for (int i = 0; i < 20; i++) pending_bytes.push_back(8'($urandom_range(255)));
    wait (pending_bytes.size() == 0 && !push);
    wait (expected_tokens.size() == 0);
    repeat (DrainWait) @(posedge clk_i);
    if (mismatches == 0 && expected_tokens.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

FILE: files.f
+incdir+rtl
rtl/slx_pkg.sv
rtl/slx_ram.sv
rtl/slx_front.sv
rtl/slx_back.sv
rtl/sql_token_lexer_core.sv
rtl/slx_checker.sv
tb/sv/sql_token_lexer_core_test.sv
